// ----- rtl/rozs_pkg.sv -----
package rozs_pkg;

    // canvas and overlay geometry
    localparam int CANVAS_WIDTH  = 1024;
    localparam int CANVAS_HEIGHT = 1024;
    localparam int CHANNELS      = 3;
    localparam int MAX_OVERLAY   = 1024;

    localparam int WORD_W  = 32;
    localparam int COORD_W = 10;
    localparam int SIZE_W  = 11;
    localparam int OFS_W   = 12;
    localparam int ZOOM_W  = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 3;

    // mapped offset (rounded rotozoom result) and canvas position widths
    localparam int MAP_W = 18;
    localparam int POS_W = 20;

    // queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OVERLAY_WIDTH  = 3'd0,
        REG_OVERLAY_HEIGHT = 3'd1,
        REG_PLACE_X        = 3'd2,
        REG_PLACE_Y        = 3'd3,
        REG_SHIFT_X        = 3'd4,
        REG_SHIFT_Y        = 3'd5,
        REG_ZOOM_COS       = 3'd6,
        REG_ZOOM_SIN       = 3'd7
    } rozs_reg_t;

    typedef enum logic [1:0] {
        TGT_A    = 2'd0,
        TGT_B    = 2'd1,
        TGT_FLOW = 2'd2
    } rozs_target_t;

    // effective configuration seen by the datapath
    typedef struct packed {
        logic        [SIZE_W-1:0] w;
        logic        [SIZE_W-1:0] h;
        logic signed [OFS_W-1:0]  px;
        logic signed [OFS_W-1:0]  py;
        logic signed [OFS_W-1:0]  sx;
        logic signed [OFS_W-1:0]  sy;
        logic signed [ZOOM_W-1:0] zc;
        logic signed [ZOOM_W-1:0] zs;
    } rozs_cfg_t;

    // one classified pixel, waiting for its writes
    typedef struct packed {
        logic [2:0][WORD_W-1:0]  sample;
        logic [COORD_W-1:0]      a_col;
        logic [COORD_W-1:0]      a_row;
        logic [COORD_W-1:0]      b_col;
        logic [COORD_W-1:0]      b_row;
        logic signed [POS_W-1:0] flow_x;
        logic signed [POS_W-1:0] flow_y;
        logic                    a_ok;
        logic                    b_ok;
    } rozs_entry_t;

    // zero clamps to 1, anything above the maximum clamps to it
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
        if (v == '0) begin
            return SIZE_W'(1);
        end else if (v > SIZE_W'(MAX_OVERLAY)) begin
            return SIZE_W'(MAX_OVERLAY);
        end
        return v;
    endfunction

endpackage

// ----- rtl/rozs_front.sv -----
module rozs_front import rozs_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  rozs_cfg_t           cfg,
    input  logic                accept,
    input  logic [WORD_W-1:0]   sample_0,
    input  logic [WORD_W-1:0]   sample_1,
    input  logic [WORD_W-1:0]   sample_2,
    output logic                push,
    output rozs_entry_t         entry
);

    // round num / 8192 half away from zero
    function automatic logic signed [MAP_W-1:0] round8192(input logic signed [30:0] num);
        logic [30:0] mag;
        logic [30:0] q;
        mag = num[30] ? 31'(-num) : 31'(num);
        q   = (mag + 31'd4096) >> 13;
        return num[30] ? MAP_W'(-$signed(q[MAP_W-1:0])) : $signed(q[MAP_W-1:0]);
    endfunction

    logic [COORD_W-1:0] scan_col_reg, scan_col_next;
    logic [COORD_W-1:0] scan_row_reg, scan_row_next;
    logic [SIZE_W-1:0]  col_p1, row_p1;

    logic signed [12:0] cx2, cy2;
    logic [2:0][WORD_W-1:0] smp_in;

    // stage 1: products
    logic                   v1_reg;
    logic signed [28:0]     p_cc_reg, p_sc_reg, p_sx_reg, p_cy_reg;
    logic [COORD_W-1:0]     i1_reg, j1_reg;
    logic [2:0][WORD_W-1:0] smp1_reg;

    // stage 2: rounded mapping
    logic signed [30:0]     num_x, num_y;
    logic                   v2_reg;
    logic signed [MAP_W-1:0] ai2_reg, aj2_reg;
    logic [COORD_W-1:0]     i2_reg, j2_reg;
    logic [2:0][WORD_W-1:0] smp2_reg;

    logic signed [POS_W-1:0] xa, ya, xb, yb;

    assign smp_in = {sample_2, sample_1, sample_0};

    assign cx2 = $signed({2'b00, scan_col_reg, 1'b0}) - $signed({2'b00, cfg.w});
    assign cy2 = $signed({2'b00, scan_row_reg, 1'b0}) - $signed({2'b00, cfg.h});

    assign col_p1 = {1'b0, scan_col_reg} + SIZE_W'(1);
    assign row_p1 = {1'b0, scan_row_reg} + SIZE_W'(1);

    always_comb begin
        scan_col_next = scan_col_reg;
        scan_row_next = scan_row_reg;
        if (accept) begin
            if (col_p1 >= cfg.w) begin
                scan_col_next = '0;
                scan_row_next = (row_p1 >= cfg.h) ? '0 : row_p1[COORD_W-1:0];
            end else begin
                scan_col_next = col_p1[COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_col_reg <= '0;
            scan_row_reg <= '0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
        end else begin
            scan_col_reg <= scan_col_next;
            scan_row_reg <= scan_row_next;
            v1_reg       <= accept;
            v2_reg       <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        p_cc_reg <= cfg.zc * cx2;
        p_sc_reg <= cfg.zs * cy2;
        p_sx_reg <= cfg.zs * cx2;
        p_cy_reg <= cfg.zc * cy2;
        i1_reg   <= scan_col_reg;
        j1_reg   <= scan_row_reg;
        for (int c = 0; c < 3; c++) begin
            smp1_reg[c] <= (c < CHANNELS) ? smp_in[c] : '0;
        end
    end

    assign num_x = $signed({8'd0, cfg.w, 12'd0}) + p_cc_reg + p_sc_reg;
    assign num_y = $signed({8'd0, cfg.h, 12'd0}) - p_sx_reg + p_cy_reg;

    always_ff @(posedge aclk) begin
        ai2_reg  <= round8192(num_x);
        aj2_reg  <= round8192(num_y);
        i2_reg   <= i1_reg;
        j2_reg   <= j1_reg;
        smp2_reg <= smp1_reg;
    end

    // stage 3: canvas positions, range checks, flow
    assign xa = POS_W'(cfg.px) + POS_W'(i2_reg);
    assign ya = POS_W'(cfg.py) + POS_W'(j2_reg);
    assign xb = POS_W'(cfg.px) + POS_W'(cfg.sx) + POS_W'(ai2_reg);
    assign yb = POS_W'(cfg.py) + POS_W'(cfg.sy) + POS_W'(aj2_reg);

    always_comb begin
        entry.sample = smp2_reg;
        entry.a_col  = xa[COORD_W-1:0];
        entry.a_row  = ya[COORD_W-1:0];
        entry.b_col  = xb[COORD_W-1:0];
        entry.b_row  = yb[COORD_W-1:0];
        entry.flow_x = POS_W'(cfg.sx) + POS_W'(ai2_reg) - POS_W'(i2_reg);
        entry.flow_y = POS_W'(cfg.sy) + POS_W'(aj2_reg) - POS_W'(j2_reg);
        entry.a_ok   = !xa[POS_W-1] && !ya[POS_W-1]
                       && (xa < POS_W'(CANVAS_WIDTH)) && (ya < POS_W'(CANVAS_HEIGHT));
        entry.b_ok   = !xb[POS_W-1] && !yb[POS_W-1]
                       && (xb < POS_W'(CANVAS_WIDTH)) && (yb < POS_W'(CANVAS_HEIGHT));
    end

    assign push = v2_reg;

endmodule

// ----- rtl/rozs_fifo.sv -----
module rozs_fifo import rozs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  rozs_entry_t wr_entry,
    input  logic        pop,
    output logic        not_empty,
    output rozs_entry_t head
);

    rozs_entry_t mem [Q_DEPTH];

    logic [Q_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_CW-1:0] count_reg;
    logic            do_pop;

    assign not_empty = (count_reg != '0);
    assign do_pop    = pop && not_empty;
    assign head      = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + Q_AW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + Q_AW'(1);
            end
            count_reg <= count_reg + Q_CW'(push) - Q_CW'(do_pop);
        end
    end

endmodule

// ----- rtl/rozs_back.sv -----
module rozs_back import rozs_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  rozs_entry_t        q_head,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_target,
    output logic [COORD_W-1:0] m_col,
    output logic [COORD_W-1:0] m_row,
    output logic [WORD_W-1:0]  m_word_0,
    output logic [WORD_W-1:0]  m_word_1,
    output logic [WORD_W-1:0]  m_word_2,
    output logic               m_last
);

    // pending writes of the current pixel: bit 0 image A, 1 image B, 2 flow
    rozs_entry_t  work_reg;
    logic [2:0]   mask_reg, mask_next;
    logic [2:0]   sel, rest;
    logic         can_emit, emit, work_free;
    rozs_target_t tgt;

    logic               m_valid_reg;
    logic [1:0]         m_target_reg;
    logic [COORD_W-1:0] m_col_reg, m_row_reg;
    logic [WORD_W-1:0]  m_word_0_reg, m_word_1_reg, m_word_2_reg;
    logic               m_last_reg;

    assign sel       = mask_reg & (~mask_reg + 3'd1);
    assign rest      = mask_reg & ~sel;
    assign can_emit  = !m_valid_reg || m_ready;
    assign emit      = (mask_reg != '0) && can_emit;
    assign work_free = (mask_reg == '0) || (emit && rest == '0);
    assign q_pop     = q_valid && work_free;

    always_comb begin
        if (q_pop) begin
            mask_next = {q_head.a_ok, q_head.b_ok, q_head.a_ok};
        end else if (emit) begin
            mask_next = rest;
        end else begin
            mask_next = mask_reg;
        end
    end

    always_comb begin
        case (sel)
            3'b001:  tgt = TGT_A;
            3'b010:  tgt = TGT_B;
            3'b100:  tgt = TGT_FLOW;
            default: tgt = TGT_A;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            mask_reg <= mask_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            work_reg <= q_head;
        end
        if (emit) begin
            m_target_reg <= tgt;
            m_last_reg   <= (rest == '0);
            case (tgt)
                TGT_B: begin
                    m_col_reg    <= work_reg.b_col;
                    m_row_reg    <= work_reg.b_row;
                    m_word_0_reg <= work_reg.sample[0];
                    m_word_1_reg <= work_reg.sample[1];
                    m_word_2_reg <= work_reg.sample[2];
                end
                TGT_FLOW: begin
                    m_col_reg    <= work_reg.a_col;
                    m_row_reg    <= work_reg.a_row;
                    m_word_0_reg <= WORD_W'(work_reg.flow_x);
                    m_word_1_reg <= WORD_W'(work_reg.flow_y);
                    m_word_2_reg <= '0;
                end
                default: begin
                    m_col_reg    <= work_reg.a_col;
                    m_row_reg    <= work_reg.a_row;
                    m_word_0_reg <= work_reg.sample[0];
                    m_word_1_reg <= work_reg.sample[1];
                    m_word_2_reg <= work_reg.sample[2];
                end
            endcase
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_target = m_target_reg;
    assign m_col    = m_col_reg;
    assign m_row    = m_row_reg;
    assign m_word_0 = m_word_0_reg;
    assign m_word_1 = m_word_1_reg;
    assign m_word_2 = m_word_2_reg;
    assign m_last   = m_last_reg;

endmodule

// ----- rtl/rotozoom_overlay_scatter.sv -----
// Rotozoom overlay scatter.
// Input channel (s_valid/s_ready, s_sample_0..2): one overlay pixel per
// transaction, in raster order. The block tracks the scan column and row.
// Output channel (m_valid/m_ready): one frame-buffer write per transaction:
// image A at place + scan, image B at place + shift + rotozoomed position,
// then the flow pair to the flow image at the image A position. Writes off
// the canvas are dropped; m_last marks the final write of a pixel, a pixel
// with no write produces no transaction.
// Path: a pixel's first write passes from its input transaction through two
// mapping stages, a queue slot, the work register and the output reg.
// Throughput: one write per cycle on the single output port while the
// receiver is ready; the next pixel is taken as the last write issues.
// The front accepts one pixel per cycle while the 4-entry queue has room.
// The user writes configuration (cfg_we/cfg_index/cfg_data) only while idle;
// the block does not enforce it. Reset (aresetn low, synchronous) clears the
// scan position, the queue and the output register, and loads the register
// defaults (identity zoom). A stalled receiver holds the output register;
// the queue then fills and s_ready drops, no transaction is lost.
module rotozoom_overlay_scatter import rozs_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [WORD_W-1:0]    s_sample_0,
    input  logic [WORD_W-1:0]    s_sample_1,
    input  logic [WORD_W-1:0]    s_sample_2,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_target,
    output logic [COORD_W-1:0]   m_col,
    output logic [COORD_W-1:0]   m_row,
    output logic [WORD_W-1:0]    m_word_0,
    output logic [WORD_W-1:0]    m_word_1,
    output logic [WORD_W-1:0]    m_word_2,
    output logic                 m_last
);

    // raw configuration registers
    logic [SIZE_W-1:0] ov_w_reg, ov_h_reg;
    logic [OFS_W-1:0]  place_x_reg, place_y_reg, shift_x_reg, shift_y_reg;
    logic [ZOOM_W-1:0] zoom_cos_reg, zoom_sin_reg;
    rozs_cfg_t         cfg;

    // credits: pixels accepted and not yet popped by the back end.
    // Bounded by the queue depth so the front pipeline never overflows it.
    logic [Q_CW-1:0] credit_reg;
    logic            accept;

    logic        push, q_valid, q_pop;
    rozs_entry_t push_entry, q_head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_w_reg     <= SIZE_W'(1);
            ov_h_reg     <= SIZE_W'(1);
            place_x_reg  <= '0;
            place_y_reg  <= '0;
            shift_x_reg  <= '0;
            shift_y_reg  <= '0;
            zoom_cos_reg <= ZOOM_W'(4096);
            zoom_sin_reg <= '0;
        end else if (cfg_we) begin
            case (rozs_reg_t'(cfg_index))
                REG_OVERLAY_WIDTH:  ov_w_reg     <= cfg_data[SIZE_W-1:0];
                REG_OVERLAY_HEIGHT: ov_h_reg     <= cfg_data[SIZE_W-1:0];
                REG_PLACE_X:        place_x_reg  <= cfg_data[OFS_W-1:0];
                REG_PLACE_Y:        place_y_reg  <= cfg_data[OFS_W-1:0];
                REG_SHIFT_X:        shift_x_reg  <= cfg_data[OFS_W-1:0];
                REG_SHIFT_Y:        shift_y_reg  <= cfg_data[OFS_W-1:0];
                REG_ZOOM_COS:       zoom_cos_reg <= cfg_data[ZOOM_W-1:0];
                REG_ZOOM_SIN:       zoom_sin_reg <= cfg_data[ZOOM_W-1:0];
                default: ;
            endcase
        end
    end

    // effective sizes clamp to 1..1024; offsets and zoom are signed
    always_comb begin
        cfg.w  = eff_size(ov_w_reg);
        cfg.h  = eff_size(ov_h_reg);
        cfg.px = $signed(place_x_reg);
        cfg.py = $signed(place_y_reg);
        cfg.sx = $signed(shift_x_reg);
        cfg.sy = $signed(shift_y_reg);
        cfg.zc = $signed(zoom_cos_reg);
        cfg.zs = $signed(zoom_sin_reg);
    end

    assign s_ready = (credit_reg < Q_CW'(Q_DEPTH));
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            credit_reg <= '0;
        end else begin
            credit_reg <= credit_reg + Q_CW'(accept) - Q_CW'(q_pop);
        end
    end

    // front: scan tracking, rotozoom mapping, classification
    rozs_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .accept   (accept),
        .sample_0 (s_sample_0),
        .sample_1 (s_sample_1),
        .sample_2 (s_sample_2),
        .push     (push),
        .entry    (push_entry)
    );

    rozs_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .wr_entry  (push_entry),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    // back: issues each pixel's pending writes, one per cycle unless stalled
    rozs_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_target (m_target),
        .m_col    (m_col),
        .m_row    (m_row),
        .m_word_0 (m_word_0),
        .m_word_1 (m_word_1),
        .m_word_2 (m_word_2),
        .m_last   (m_last)
    );

endmodule

// ----- rtl/rozs_checker.sv -----
module rozs_checker import rozs_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [1:0]           m_target,
    input logic [COORD_W-1:0]   m_col,
    input logic [COORD_W-1:0]   m_row,
    input logic [WORD_W-1:0]    m_word_0,
    input logic [WORD_W-1:0]    m_word_1,
    input logic [WORD_W-1:0]    m_word_2,
    input logic                 m_last
);

    // output register is empty right after reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid set after reset");

    // a flow write always closes its pixel
    a_flow_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_target == TGT_FLOW |-> m_last && m_word_2 == '0)
        else $error("flow write not last or channel 2 nonzero");

    // an image A write is always followed by the flow write of that pixel
    a_a_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_target == TGT_A |-> !m_last)
        else $error("image A write marked last");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_target) && $stable(m_col)
            && $stable(m_row) && $stable(m_word_0) && $stable(m_word_1)
            && $stable(m_word_2) && $stable(m_last))
        else $error("stalled output changed");

endmodule

bind rotozoom_overlay_scatter rozs_checker u_rozs_checker (.*);
